// File: design/euxyz_pkg.sv
// ----------------------------------------------------------------------------
// euxyz_pkg
// Shared types and constants of the Euler X-Y-Z vector rotator.
// ----------------------------------------------------------------------------
package euxyz_pkg;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int COEF_WIDTH         = 16;
  localparam int REG_COUNT          = 6;
  localparam int CFG_INDEX_WIDTH    = 3;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } reg_index_t;

  typedef struct packed {
    coef_t cos_x;
    coef_t sin_x;
    coef_t cos_y;
    coef_t sin_y;
    coef_t cos_z;
    coef_t sin_z;
  } coef_set_t;

endpackage

// File: design/euxyz_cfg_regs.sv
// ----------------------------------------------------------------------------
// euxyz_cfg_regs
// Cosine and sine registers of the three axes; reset gives the identity.
// ----------------------------------------------------------------------------
module euxyz_cfg_regs import euxyz_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]      cfg_data,
  output coef_set_t                  coefs
);

  localparam coef_t COEF_ONE = COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);

  coef_set_t coefs_r;
  coef_set_t coefs_nxt;

  always_comb begin
    coefs_nxt = coefs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_COS_X: coefs_nxt.cos_x = coef_t'(cfg_data);
        REG_SIN_X: coefs_nxt.sin_x = coef_t'(cfg_data);
        REG_COS_Y: coefs_nxt.cos_y = coef_t'(cfg_data);
        REG_SIN_Y: coefs_nxt.sin_y = coef_t'(cfg_data);
        REG_COS_Z: coefs_nxt.cos_z = coef_t'(cfg_data);
        REG_SIN_Z: coefs_nxt.sin_z = coef_t'(cfg_data);
        default:   coefs_nxt = coefs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.cos_x <= COEF_ONE;
      coefs_r.sin_x <= '0;
      coefs_r.cos_y <= COEF_ONE;
      coefs_r.sin_y <= '0;
      coefs_r.cos_z <= COEF_ONE;
      coefs_r.sin_z <= '0;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

  assign coefs = coefs_r;

endmodule

// File: design/euxyz_rot_cell.sv
// ----------------------------------------------------------------------------
// euxyz_rot_cell
// Two-stage plane rotation: a' = c*a - s*b, b' = s*a + c*b, rounded per term
// and saturated; the third coordinate travels alongside.
// ----------------------------------------------------------------------------
module euxyz_rot_cell import euxyz_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] in_a,
  input  logic signed [COORD_WIDTH-1:0] in_b,
  input  logic signed [COORD_WIDTH-1:0] in_pass,
  input  coef_t                         coef_c,
  input  coef_t                         coef_s,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_a,
  output logic signed [COORD_WIDTH-1:0] out_b,
  output logic signed [COORD_WIDTH-1:0] out_pass
);

  localparam int KW = COEF_WIDTH + 1;
  localparam int PW = KW + COORD_WIDTH;
  localparam int TW = PW - COEF_FRAC_BITS;
  localparam int SW = TW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (COEF_FRAC_BITS - 1));

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-COORD_WIDTH:0] top;
    logic signed [COORD_WIDTH-1:0] res;
    top = v[SW-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      res = v[COORD_WIDTH-1:0];
    end else if (v[SW-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [TW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = (p + HALF) >>> COEF_FRAC_BITS;
    return q[TW-1:0];
  endfunction

  logic signed [KW-1:0] c_ext;
  logic signed [KW-1:0] s_ext;
  logic signed [KW-1:0] ns_ext;

  logic signed [PW-1:0] ac_r, as_r, bns_r, bc_r;
  logic signed [PW-1:0] ac_nxt, as_nxt, bns_nxt, bc_nxt;
  logic signed [COORD_WIDTH-1:0] pass1_r;
  logic                          valid1_r;

  logic signed [SW-1:0]          sum_a, sum_b;
  logic signed [COORD_WIDTH-1:0] a2_r, b2_r, pass2_r;
  logic signed [COORD_WIDTH-1:0] a2_nxt, b2_nxt;
  logic                          valid2_r;

  assign c_ext  = {coef_c[COEF_WIDTH-1], coef_c};
  assign s_ext  = {coef_s[COEF_WIDTH-1], coef_s};
  assign ns_ext = -s_ext;

  assign ac_nxt  = PW'(c_ext)  * PW'(in_a);
  assign as_nxt  = PW'(s_ext)  * PW'(in_a);
  assign bns_nxt = PW'(ns_ext) * PW'(in_b);
  assign bc_nxt  = PW'(c_ext)  * PW'(in_b);

  assign sum_a  = SW'(rnd(ac_r)) + SW'(rnd(bns_r));
  assign sum_b  = SW'(rnd(as_r)) + SW'(rnd(bc_r));
  assign a2_nxt = sat(sum_a);
  assign b2_nxt = sat(sum_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    ac_r    <= ac_nxt;
    as_r    <= as_nxt;
    bns_r   <= bns_nxt;
    bc_r    <= bc_nxt;
    pass1_r <= in_pass;
    a2_r    <= a2_nxt;
    b2_r    <= b2_nxt;
    pass2_r <= pass1_r;
  end

  assign out_valid = valid2_r;
  assign out_a     = a2_r;
  assign out_b     = b2_r;
  assign out_pass  = pass2_r;

endmodule

// File: design/euler_xyz_vector_rotator.sv
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotator
// Rotates a signed fixed-point 3D vector about X, then Y, then Z.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy is always
// low. Three rotation cells in a row, one per axis, each two register stages
// deep, give a rate of one request per cycle. The
// result shows on out_x, out_y and out_z for the single cycle in which
// out_valid is high and must be captured then, as the block cannot be
// stalled. Configuration registers should only be written while no request
// is in flight.
module euler_xyz_vector_rotator import euxyz_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [COEF_WIDTH-1:0]         cfg_data
);

  coef_set_t coefs;
  logic      accept;

  logic                          v1, v2;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1;
  logic signed [COORD_WIDTH-1:0] x2, y2, z2;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  euxyz_cfg_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .coefs    (coefs)
  );

  euxyz_rot_cell #(
    .COORD_WIDTH   (COORD_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cell_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_a     (in_y),
    .in_b     (in_z),
    .in_pass  (in_x),
    .coef_c   (coefs.cos_x),
    .coef_s   (coefs.sin_x),
    .out_valid(v1),
    .out_a    (y1),
    .out_b    (z1),
    .out_pass (x1)
  );

  euxyz_rot_cell #(
    .COORD_WIDTH   (COORD_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cell_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v1),
    .in_a     (z1),
    .in_b     (x1),
    .in_pass  (y1),
    .coef_c   (coefs.cos_y),
    .coef_s   (coefs.sin_y),
    .out_valid(v2),
    .out_a    (z2),
    .out_b    (x2),
    .out_pass (y2)
  );

  euxyz_rot_cell #(
    .COORD_WIDTH   (COORD_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cell_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v2),
    .in_a     (x2),
    .in_b     (y2),
    .in_pass  (z2),
    .coef_c   (coefs.cos_z),
    .coef_s   (coefs.sin_z),
    .out_valid(out_valid),
    .out_a    (out_x),
    .out_b    (out_y),
    .out_pass (out_z)
  );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Euler X-Y-Z vector rotator. An in-bench
// predictor rotates each accepted point with its own copy of the coefficient
// registers, and every output strobe is compared field by field with the
// oldest prediction. A directed part covers reset identity, rounding ties,
// saturation and ignored register indexes. A random part follows with
// several coefficient sets and different request pacing.
// ----------------------------------------------------------------------------
module tb;
  import euxyz_pkg::*;

  localparam int CW             = COORD_WIDTH_DEF;
  localparam int FRAC           = COEF_FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 100;

  localparam logic [CFG_INDEX_WIDTH-1:0] SPARE_INDEX_LO = CFG_INDEX_WIDTH'(REG_COUNT);
  localparam logic [CFG_INDEX_WIDTH-1:0] SPARE_INDEX_HI = '1;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam coef_t COEF_ONE  = coef_t'(1 << FRAC);
  localparam coef_t COEF_HALF = coef_t'(1 << (FRAC - 1));
  localparam coef_t COEF_MAX  = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam coef_t COEF_MIN  = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        start     = 1'b0;
  logic signed [CW-1:0]        in_x      = '0;
  logic signed [CW-1:0]        in_y      = '0;
  logic signed [CW-1:0]        in_z      = '0;
  logic                        cfg_we    = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
  logic [COEF_WIDTH-1:0]       cfg_data  = '0;
  logic                        busy;
  logic                        out_valid;
  logic signed [CW-1:0]        out_x;
  logic signed [CW-1:0]        out_y;
  logic signed [CW-1:0]        out_z;

  coef_t  coef_reg [REG_COUNT];
  point_t rotated_points [$];
  point_t head_point;
  int     mismatches  = 0;
  int     idle_cycles = 0;

  euler_xyz_vector_rotator #(
    .COORD_WIDTH   (CW),
    .COEF_FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .out_valid(out_valid),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint round_term(input longint k, input longint v);
    return (k * v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic turn_plane(inout longint a, inout longint b, input coef_t c, input coef_t s);
    longint na;
    longint nb;
    na = clamp_coord(round_term(c, a) + round_term(-longint'(s), b));
    nb = clamp_coord(round_term(s, a) + round_term(c, b));
    a = na;
    b = nb;
  endtask

  task automatic rotate_xyz(input point_t p, output point_t r);
    longint x;
    longint y;
    longint z;
    x = $signed(p.x);
    y = $signed(p.y);
    z = $signed(p.z);
    turn_plane(y, z, coef_reg[REG_COS_X], coef_reg[REG_SIN_X]);
    turn_plane(z, x, coef_reg[REG_COS_Y], coef_reg[REG_SIN_Y]);
    turn_plane(x, y, coef_reg[REG_COS_Z], coef_reg[REG_SIN_Z]);
    r.x = x[CW-1:0];
    r.y = y[CW-1:0];
    r.z = z[CW-1:0];
  endtask

  function automatic point_t make_point(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic logic signed [CW-1:0] random_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return CW'(int'($urandom_range(2)) - 1);
      3, 4: return CW'(int'($urandom_range(1 << 21)) - (1 << 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic coef_t random_coef();
    case ($urandom_range(7))
      0: return COEF_ONE;
      1: return -COEF_ONE;
      2: return '0;
      3: return COEF_HALF;
      4, 5: return coef_t'(int'($urandom_range(32768)) - 16384);
      6: return coef_t'($urandom());
      default: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
    endcase
  endfunction

  task automatic send_point(input point_t p);
    point_t want;
    start <= 1'b1;
    in_x  <= p.x;
    in_y  <= p.y;
    in_z  <= p.z;
    do @(posedge clk); while (busy);
    rotate_xyz(p, want);
    rotated_points.push_back(want);
  endtask

  task automatic pace(input int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (rotated_points.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx, input coef_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx < REG_COUNT) coef_reg[idx] = val;
  endtask

  // Writes to the two unused indexes must leave the coefficients untouched.
  task automatic set_coefs(input coef_t cx, input coef_t sx, input coef_t cy,
                           input coef_t sy, input coef_t cz, input coef_t sz,
                           input coef_t spare);
    drain_results();
    cfg_write(REG_COS_X, cx);
    cfg_write(REG_SIN_X, sx);
    cfg_write(REG_COS_Y, cy);
    cfg_write(REG_SIN_Y, sy);
    cfg_write(REG_COS_Z, cz);
    cfg_write(REG_SIN_Z, sz);
    cfg_write(SPARE_INDEX_LO, spare);
    cfg_write(SPARE_INDEX_HI, ~spare);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic signed [CW-1:0] want,
                                 input logic signed [CW-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rotated_points.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with no request pending: (%0d, %0d, %0d)", out_x, out_y, out_z);
      end else begin
        head_point = rotated_points.pop_front();
        if (out_x !== head_point.x) report_mismatch("out_x", head_point.x, out_x);
        if (out_y !== head_point.y) report_mismatch("out_y", head_point.y, out_y);
        if (out_z !== head_point.z) report_mismatch("out_z", head_point.z, out_z);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("euler_xyz_vector_rotator verification failed");
      $finish;
    end
  end

  task automatic test_reset_identity();
    send_point(make_point('0, '0, '0));
    send_point(make_point(COORD_MAX, COORD_MIN, 1));
    send_point(make_point(COORD_MIN, COORD_MAX, -1));
  endtask

  task automatic test_rounding_and_saturation();
    // Half coefficients put odd products exactly on a rounding tie.
    set_coefs(COEF_HALF, COEF_HALF, COEF_HALF, COEF_HALF, COEF_HALF, COEF_HALF, '0);
    send_point(make_point(1, -1, 3));
    send_point(make_point(-1, 1, -3));
    // Coefficients beyond plus or minus one drive every stage into saturation.
    set_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX));
    send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN));
    send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX));
    set_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    send_point(make_point(COORD_MIN, COORD_MAX, -1));
    // Quarter turns about every axis.
    set_coefs('0, COEF_ONE, '0, COEF_ONE, '0, COEF_ONE, COEF_HALF);
    send_point(make_point(32'sd65536, 32'sd131072, -32'sd196608));
    set_coefs(-COEF_ONE, -COEF_ONE, -COEF_ONE, -COEF_ONE, -COEF_ONE, -COEF_ONE, '1);
    send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX));
  endtask

  task automatic test_spare_index();
    set_coefs(COEF_ONE, '0, COEF_ONE, '0, COEF_ONE, '0, COEF_MIN);
    send_point(make_point(COORD_MAX, -5, 7));
    send_point(make_point(-123456, COORD_MIN, 98765));
  endtask

  task automatic test_random_streams();
    int pct;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      set_coefs(random_coef(), random_coef(), random_coef(), random_coef(),
                random_coef(), random_coef(), coef_t'($urandom()));
      case (phase % 3)
        0: pct = 0;
        1: pct = 88;
        default: pct = 35;
      endcase
      repeat (PHASE_ITEMS) begin
        pace(pct);
        send_point(make_point(random_coord(), random_coord(), random_coord()));
      end
    end
  endtask

  initial begin
    coef_reg[REG_COS_X] = COEF_ONE;
    coef_reg[REG_SIN_X] = '0;
    coef_reg[REG_COS_Y] = COEF_ONE;
    coef_reg[REG_SIN_Y] = '0;
    coef_reg[REG_COS_Z] = COEF_ONE;
    coef_reg[REG_SIN_Z] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_identity();
    test_rounding_and_saturation();
    test_spare_index();
    test_random_streams();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rotated_points.size() == 0) begin
      $display("euler_xyz_vector_rotator verification clean");
    end else begin
      $display("euler_xyz_vector_rotator verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/euxyz_pkg.sv
design/euxyz_cfg_regs.sv
design/euxyz_rot_cell.sv
design/euler_xyz_vector_rotator.sv
bench/tb.sv
